// ===== sv/rrq_pkg.sv =====
// Package for the round-robin run queue: command and status codes, word types.
// No dependencies.
`default_nettype none
package rrq_pkg;
  localparam logic [2:0] CMD_ENQ   = 3'd0;
  localparam logic [2:0] CMD_DEQ   = 3'd1;
  localparam logic [2:0] CMD_YIELD = 3'd2;
  localparam logic [2:0] CMD_PICK  = 3'd3;
  localparam logic [2:0] CMD_STEAL = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  localparam int unsigned MAX_RESULTS = 32;

  typedef struct packed {
    logic [2:0]  command;
    logic [5:0]  process_id;
    logic [63:0] runnable_mask;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] result_process;
    logic       result_valid;
    logic [6:0] queue_count;
    logic       last;
  } res_word_t;
endpackage
`default_nettype wire

// ===== sv/rrq_if.sv =====
// Valid/ready channel interfaces for command and result words.
// Depends on rrq_pkg.
`default_nettype none
interface rrq_cmd_if;
  logic                valid;
  logic                ready;
  rrq_pkg::cmd_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rrq_res_if;
  logic                valid;
  logic                ready;
  rrq_pkg::res_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/rrq_mem.sv =====
// Single-port-write, single-read link memory with registered read data.
// No dependencies.
`default_nettype none
module rrq_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 7
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== sv/round_robin_run_queue_top.sv =====
// Top level of the round-robin run queue: sequencer over three slot memories.
// Depends on rrq_pkg, rrq_if and rrq_mem.
//
// Usage: command words enter on cmd (enqueue, dequeue, yield, pick, steal);
// result words leave on res. Each command gives one result word, except steal,
// which gives one word per removed entry, the final one flagged last.
// One command is handled at a time; ready is low until its last result has
// been taken. Every memory access is an address step followed by a
// registered read. Dequeue and pick walk the ring one slot at a time.
// A new command is taken in the cycle after the last word has left.
// After reset a clearing pass rebuilds the free chain and marks all slots
// free; no command is accepted during it.
// A stalled receiver holds the result word in the output register and the
// sequencer waits; nothing is lost.
`default_nettype none
module round_robin_run_queue_top #(
  parameter int unsigned SLOTS = 64
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  rrq_cmd_if.sink   cmd,
  rrq_res_if.source res
);
  import rrq_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned LW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  localparam logic [4:0] S_INIT  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_RD    = 5'd2;
  localparam logic [4:0] S_DISP  = 5'd3;
  localparam logic [4:0] S_ENQ1  = 5'd4;
  localparam logic [4:0] S_ENQ2  = 5'd5;
  localparam logic [4:0] S_ENQ3  = 5'd6;
  localparam logic [4:0] S_WALK  = 5'd7;
  localparam logic [4:0] S_WCHK  = 5'd8;
  localparam logic [4:0] S_UNL1  = 5'd9;
  localparam logic [4:0] S_UNL2  = 5'd10;
  localparam logic [4:0] S_UNL3  = 5'd11;
  localparam logic [4:0] S_OUT   = 5'd12;
  localparam logic [4:0] S_PWALK = 5'd13;
  localparam logic [4:0] S_PCHK  = 5'd14;
  localparam logic [4:0] S_SCHK  = 5'd15;
  localparam logic [4:0] S_SWAIT = 5'd16;
  localparam logic [4:0] S_SOUT  = 5'd17;
  localparam logic [4:0] S_UNL0  = 5'd18;

  logic [4:0]    state_q, state_d;
  logic [LW-1:0] free_q, free_d, head_q, head_d, cnt_q, cnt_d;
  logic [LW-1:0] cur_q, cur_d, aux_q, aux_d, nx_q, nx_d;
  logic [AW:0]   step_q, step_d;
  logic [5:0]    left_q, left_d;
  cmd_word_t     cw_q, cw_d;
  logic          rv_q, rv_d;
  res_word_t     rw_q, rw_d;
  logic [5:0]    taken_q, taken_d;

  logic          nwe, pwe, swe;
  logic [AW-1:0] nwa, pwa, swa, ra;
  logic [LW-1:0] nwd, pwd, nrd, prd;
  logic [5:0]    swd, srd;

  rrq_mem #(.DEPTH(SLOTS), .WIDTH(LW)) u_next (.clk_i, .we_i(nwe), .waddr_i(nwa),
    .wdata_i(nwd), .raddr_i(ra), .rdata_o(nrd));
  rrq_mem #(.DEPTH(SLOTS), .WIDTH(LW)) u_prev (.clk_i, .we_i(pwe), .waddr_i(pwa),
    .wdata_i(pwd), .raddr_i(ra), .rdata_o(prd));
  rrq_mem #(.DEPTH(SLOTS), .WIDTH(6)) u_proc (.clk_i, .we_i(swe), .waddr_i(swa),
    .wdata_i(swd), .raddr_i(ra), .rdata_o(srd));

  function automatic logic [LW-1:0] lnk(input logic [LW-1:0] v);
    return (v < NIL) ? v : NIL;
  endfunction

  assign cmd.ready = (state_q == S_IDLE) && !rv_q;
  assign res.valid = rv_q;
  assign res.data  = rw_q;

  logic [LW-1:0] nrl, prl;
  assign nrl = lnk(nrd);
  assign prl = lnk(prd);

  always_comb begin
    state_d = state_q; free_d = free_q; head_d = head_q; cnt_d = cnt_q;
    cur_d = cur_q; aux_d = aux_q; nx_d = nx_q; step_d = step_q;
    left_d = left_q; cw_d = cw_q; taken_d = taken_q;
    rv_d = rv_q; rw_d = rw_q;
    nwe = 1'b0; pwe = 1'b0; swe = 1'b0;
    nwa = cur_q[AW-1:0]; pwa = cur_q[AW-1:0]; swa = cur_q[AW-1:0];
    nwd = NIL; pwd = NIL; swd = cw_q.process_id;
    ra  = cur_q[AW-1:0];
    if (rv_q && res.ready) rv_d = 1'b0;
    unique case (state_q)
      S_INIT: begin
        nwe = 1'b1; pwe = 1'b1;
        nwd = (step_q[AW-1:0] == AW'(SLOTS - 1)) ? NIL : LW'(step_q) + 1'b1;
        nwa = step_q[AW-1:0]; pwa = step_q[AW-1:0];
        step_d = step_q + 1'b1;
        if (step_q[AW-1:0] == AW'(SLOTS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.valid && !rv_q) begin
          cw_d = cmd.data;
          cur_d = head_q;
          state_d = S_RD;
        end
      end
      S_RD: begin
        ra = cur_q[AW-1:0];
        state_d = S_DISP;
      end
      S_DISP: begin
        rw_d = '{status: ST_OK, result_process: 6'd0, result_valid: 1'b0,
                 queue_count: 7'(cnt_q), last: 1'b1};
        unique case (cw_q.command)
          CMD_ENQ: begin
            if (free_q == NIL) begin
              rw_d.status = ST_FULL; state_d = S_OUT;
            end else begin
              aux_d = cur_q; cur_d = free_q;
              aux_d = prl; nx_d = head_q;
              state_d = S_ENQ1;
            end
          end
          CMD_DEQ: begin
            if (head_q == NIL) begin
              rw_d.status = ST_ABSENT; state_d = S_OUT;
            end else if (srd == cw_q.process_id) begin
              state_d = S_UNL0;
            end else begin
              cur_d = prl; step_d = '0; state_d = S_WALK;
            end
          end
          CMD_YIELD: begin
            if (head_q == NIL) rw_d.status = ST_NONE;
            else head_d = nrl;
            state_d = S_OUT;
          end
          CMD_PICK: begin
            if (head_q == NIL) begin
              rw_d.status = ST_NONE; state_d = S_OUT;
            end else begin
              step_d = '0; state_d = S_PCHK;
            end
          end
          CMD_STEAL: begin
            left_d = (32'(cnt_q >> 1) > MAX_RESULTS) ? 6'(MAX_RESULTS) : 6'(cnt_q >> 1);
            if (head_q == NIL || cnt_q < LW'(2)) begin
              rw_d.status = ST_NONE; state_d = S_OUT;
            end else begin
              // every removed entry follows the head, so all of them go
              cnt_d = cnt_q - LW'(left_d);
              cur_d = nrl; state_d = S_SWAIT;
            end
          end
          default: begin
            rw_d.status = ST_NONE; state_d = S_OUT;
          end
        endcase
      end
      S_ENQ1: begin
        // cur = new slot, aux = tail (prev of head), nx = head; read free next
        ra = cur_q[AW-1:0];
        state_d = S_ENQ2;
      end
      S_ENQ2: begin
        free_d = nrl;
        swe = 1'b1;
        if (nx_q == NIL) begin
          head_d = cur_q;
          nwe = 1'b1; nwd = cur_q; pwe = 1'b1; pwd = cur_q;
          state_d = S_ENQ3;
        end else begin
          if (aux_q == NIL) aux_d = nx_q;
          nwe = 1'b1; nwd = nx_q; pwe = 1'b1;
          pwd = (aux_q == NIL) ? nx_q : aux_q;
          state_d = S_ENQ3;
        end
      end
      S_ENQ3: begin
        if (nx_q != NIL) begin
          nwe = 1'b1; nwa = aux_q[AW-1:0]; nwd = cur_q;
          pwe = 1'b1; pwa = nx_q[AW-1:0]; pwd = cur_q;
        end
        cnt_d = cnt_q + 1'b1;
        rw_d.queue_count = 7'(cnt_q + 1'b1);
        state_d = S_OUT;
      end
      S_WALK: begin
        if (cur_q == NIL || cur_q == head_q || step_q == (AW+1)'(SLOTS)) begin
          rw_d.status = ST_ABSENT; state_d = S_OUT;
        end else begin
          ra = cur_q[AW-1:0]; state_d = S_WCHK;
        end
      end
      S_WCHK: begin
        if (srd == cw_q.process_id) state_d = S_UNL0;
        else begin
          cur_d = prl; step_d = step_q + 1'b1; state_d = S_WALK;
        end
      end
      S_UNL0: begin
        // links of cur are already on the read port
        aux_d = prl; nx_d = nrl;
        state_d = S_UNL1;
      end
      S_UNL1: begin
        if (nx_q == cur_q) head_d = NIL;
        else begin
          if (aux_q != NIL) begin
            nwe = 1'b1; nwa = aux_q[AW-1:0]; nwd = nx_q;
          end
          if (nx_q != NIL) begin
            pwe = 1'b1; pwa = nx_q[AW-1:0]; pwd = aux_q;
          end
          if (cw_q.command == CMD_DEQ) head_d = nx_q;
        end
        state_d = S_UNL2;
      end
      S_UNL2: begin
        nwe = 1'b1; nwd = free_q; pwe = 1'b1; pwd = NIL;
        free_d = cur_q;
        state_d = S_UNL3;
      end
      S_UNL3: begin
        if (cw_q.command == CMD_DEQ) begin
          if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
          rw_d.queue_count = 7'(cnt_d);
          state_d = S_OUT;
        end else begin
          left_d = left_q - 1'b1;
          cur_d = nx_q; state_d = S_SOUT;
        end
      end
      S_OUT: begin
        if (!rv_q || res.ready) begin
          rv_d = 1'b1; state_d = S_IDLE;
        end
      end
      S_PCHK: begin
        ra = cur_q[AW-1:0]; state_d = S_PWALK;
      end
      S_PWALK: begin
        if (cw_q.runnable_mask[srd]) begin
          rw_d.result_process = srd; rw_d.result_valid = 1'b1;
          state_d = S_OUT;
        end else if (nrl == NIL || nrl == head_q ||
                     step_q == (AW+1)'(SLOTS - 1)) begin
          rw_d.status = ST_NONE; state_d = S_OUT;
        end else begin
          cur_d = nrl; step_d = step_q + 1'b1; state_d = S_PCHK;
        end
      end
      S_SWAIT: begin
        ra = cur_q[AW-1:0]; state_d = S_SCHK;
      end
      S_SCHK: begin
        taken_d = srd;
        aux_d = prl; nx_d = nrl;
        state_d = S_UNL1;
      end
      S_SOUT: begin
        // one word per removed entry, all with the final count
        if (!rv_q || res.ready) begin
          rw_d = '{status: ST_OK, result_process: taken_q, result_valid: 1'b1,
                   queue_count: 7'(cnt_q), last: (left_q == '0)};
          rv_d = 1'b1;
          state_d = (left_q == '0) ? S_IDLE : S_SWAIT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; free_q <= '0; head_q <= NIL; cnt_q <= '0;
      step_q <= '0; rv_q <= 1'b0;
    end else begin
      state_q <= state_d; free_q <= free_d; head_q <= head_d; cnt_q <= cnt_d;
      step_q <= step_d; rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; aux_q <= aux_d; nx_q <= nx_d; left_q <= left_d;
    cw_q <= cw_d; rw_q <= rw_d; taken_q <= taken_d;
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LW'(SLOTS)) else $error("count above SLOTS");
  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((cnt_q == '0) == (head_q == NIL)))
    else $error("head and count disagree");
  a_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.valid && cmd.ready) |=> !cmd.ready) else $error("ready while busy");
`endif
endmodule
`default_nettype wire
